/* hdl/tlik_pkg.sv */
// ----------------------------------------------------------------------------
// tlik_pkg: shared types and constants
// Payload structs, datapath widths, pipeline depths and the CORDIC arctan table.
// ----------------------------------------------------------------------------
package tlik_pkg;

	localparam int LINK_W     = 15;
	localparam int COORD_W    = 16;
	localparam int ANG_OUT_W  = 16;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int D2_W       = 2 * DIFF_W;
	localparam int K_W        = D2_W + 1;
	localparam int H_W        = 32;
	localparam int RAD_W      = 2 * H_W;
	localparam int REM_W      = H_W + 4;
	localparam int V_W        = 52;
	localparam int CW         = 54;
	localparam int M_W        = V_W;
	localparam int NORM_TOP   = 47;
	localparam int NORM_N     = 6;
	localparam int SQRT_N     = 32;
	localparam int CORDIC_N   = 32;
	localparam int ANG_LAT    = NORM_N + 1 + CORDIC_N + 1;
	localparam int PIPE_LAT   = 5 + SQRT_N + 2 + ANG_LAT + 1;

	localparam logic [LINK_W-1:0] LINK_RESET = 15'd1280;

	typedef enum logic {
		CFG_UPPER = 1'b0,
		CFG_LOWER = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] hip_x;
		logic signed [COORD_W-1:0] hip_y;
		logic signed [COORD_W-1:0] foot_x;
		logic signed [COORD_W-1:0] foot_y;
	} req_t;

	typedef struct packed {
		logic                        solution_valid;
		logic signed [ANG_OUT_W-1:0] hip_angle;
		logic signed [ANG_OUT_W-1:0] knee_angle;
	} res_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [H_W-1:0]   root;
	} sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          z;
	} cord_t;

	localparam logic [31:0] ATAN_TABLE [CORDIC_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

endpackage

/* hdl/two_link_leg_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// two_link_leg_inverse_kinematics: knee solve by circle intersection
// Fully pipelined; hip and knee angles from a shared geometry front end.
// ----------------------------------------------------------------------------
// Usage:
//   A request (hip and foot points) is taken on any clock with start high;
//   busy stays low, so one request can be issued every cycle.
//   Each request yields one result on res, in order, on a one-cycle done pulse.
//   Latency is set by the 32-cell square-root chain, the 32-cell CORDIC
//   chains (one per angle, running side by side) and the normalize stages.
//   Throughput: one request per cycle.
//   Link lengths are written on the cfg channel (cfg_ready is always high)
//   and must only change while no request is in flight.
//   Reset clears the in-flight markers and sets both links to 1280 (5.0).
//   The receiver cannot stall: every result must be taken when done pulses.
//   With no intersection or coincident points, solution_valid is 0 and
//   both angles are 0.
// ----------------------------------------------------------------------------
module two_link_leg_inverse_kinematics #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tlik_pkg::req_t                req,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  tlik_pkg::cfg_idx_t            cfg_index,
	input  logic [tlik_pkg::LINK_W-1:0]   cfg_data,
	output logic                          done,
	output tlik_pkg::res_t                res
);
	import tlik_pkg::*;

	typedef struct packed {
		logic signed [K_W-1:0]    k;
		logic signed [K_W-1:0]    kp;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic                     sol;
	} side_t;

	logic [LINK_W-1:0]         upper_q;
	logic [LINK_W-1:0]         lower_q;
	logic [PIPE_LAT-1:0]       vld_q;

	logic signed [DIFF_W-1:0]  dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [D2_W-1:0]    dxsq_s2, dysq_s2;
	logic [2*(LINK_W+1)-1:0]   sumsq_s2, sumsq_s3;
	logic [2*LINK_W-1:0]       difsq_s2, difsq_s3;
	logic signed [2*LINK_W:0]  rr_s2, rr_s3;
	logic [D2_W-1:0]           d2_s3;
	logic [H_W-1:0]            a_s4, b_s4;
	side_t                     side_s4, side_s5;
	logic [RAD_W-1:0]          prod_s5;
	side_t                     side_d [SQRT_N];
	sqrt_t                     sq_c [SQRT_N+1];

	logic [LINK_W:0]           sum_w;
	logic [LINK_W-1:0]         dif_w;

	logic signed [V_W-1:0]     kdx_s6, kdy_s6, kpdx_s6, kpdy_s6, hdx_s6, hdy_s6;
	logic                      pick_s6, sol_s6;
	logic signed [V_W-1:0]     hvx_s7, hvy_s7, kvx_s7, kvy_s7;
	logic                      sol_s7;
	logic [ANG_LAT-1:0]        sol_d;
	logic signed [H_W:0]       h_w;
	logic signed [ANG_OUT_W-1:0] hip_ang, knee_ang;
	res_t                      res_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= LINK_RESET;
			lower_q <= LINK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_UPPER: upper_q <= cfg_data;
				CFG_LOWER: lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], start & ~busy};
		end
	end

	assign sum_w = (LINK_W+1)'(upper_q) + (LINK_W+1)'(lower_q);
	assign dif_w = (upper_q > lower_q) ? upper_q - lower_q : lower_q - upper_q;

	// geometry front end
	always_ff @(posedge clk) begin
		dx_s1 <= DIFF_W'(req.foot_x) - DIFF_W'(req.hip_x);
		dy_s1 <= DIFF_W'(req.foot_y) - DIFF_W'(req.hip_y);

		dxsq_s2  <= D2_W'(dx_s1 * dx_s1);
		dysq_s2  <= D2_W'(dy_s1 * dy_s1);
		sumsq_s2 <= sum_w * sum_w;
		difsq_s2 <= dif_w * dif_w;
		rr_s2    <= $signed({1'b0, (2*LINK_W)'(upper_q * upper_q)})
			- $signed({1'b0, (2*LINK_W)'(lower_q * lower_q)});
		dx_s2    <= dx_s1;
		dy_s2    <= dy_s1;

		d2_s3    <= D2_W'(dxsq_s2) + D2_W'(dysq_s2);
		sumsq_s3 <= sumsq_s2;
		difsq_s3 <= difsq_s2;
		rr_s3    <= rr_s2;
		dx_s3    <= dx_s2;
		dy_s3    <= dy_s2;

		side_s4.sol <= (d2_s3 != '0) && (d2_s3 <= D2_W'(sumsq_s3))
			&& (d2_s3 >= D2_W'(difsq_s3));
		a_s4        <= H_W'(D2_W'(sumsq_s3) - d2_s3);
		b_s4        <= H_W'(d2_s3 - D2_W'(difsq_s3));
		side_s4.k   <= $signed({1'b0, d2_s3}) + K_W'(rr_s3);
		side_s4.kp  <= $signed({1'b0, d2_s3}) - K_W'(rr_s3);
		side_s4.dx  <= dx_s3;
		side_s4.dy  <= dy_s3;

		prod_s5 <= a_s4 * b_s4;
		side_s5 <= side_s4;
	end

	// side data rides alongside the root chain
	always_ff @(posedge clk) begin
		side_d[0] <= side_s5;
		for (int i = 1; i < SQRT_N; i++) begin
			side_d[i] <= side_d[i-1];
		end
	end

	assign sq_c[0] = '{rad: prod_s5, rem: '0, root: '0};

	for (genvar j = 0; j < SQRT_N; j++) begin : g_sqrt
		tlik_sqrt_cell u_cell (
			.clk (clk),
			.d   (sq_c[j]),
			.q   (sq_c[j+1])
		);
	end

	assign h_w = $signed({1'b0, sq_c[SQRT_N].root});

	always_ff @(posedge clk) begin
		kdx_s6  <= V_W'(side_d[SQRT_N-1].k * side_d[SQRT_N-1].dx);
		kdy_s6  <= V_W'(side_d[SQRT_N-1].k * side_d[SQRT_N-1].dy);
		kpdx_s6 <= V_W'(side_d[SQRT_N-1].kp * side_d[SQRT_N-1].dx);
		kpdy_s6 <= V_W'(side_d[SQRT_N-1].kp * side_d[SQRT_N-1].dy);
		hdx_s6  <= V_W'(h_w * side_d[SQRT_N-1].dx);
		hdy_s6  <= V_W'(h_w * side_d[SQRT_N-1].dy);
		// first intersection only when its x is strictly larger
		pick_s6 <= (sq_c[SQRT_N].root != '0) && !side_d[SQRT_N-1].dy[DIFF_W-1]
			&& (side_d[SQRT_N-1].dy != '0);
		sol_s6  <= side_d[SQRT_N-1].sol;

		if (pick_s6) begin
			hvx_s7 <= kdx_s6 + hdy_s6;
			hvy_s7 <= kdy_s6 - hdx_s6;
			kvx_s7 <= kpdx_s6 - hdy_s6;
			kvy_s7 <= kpdy_s6 + hdx_s6;
		end else begin
			hvx_s7 <= kdx_s6 - hdy_s6;
			hvy_s7 <= kdy_s6 + hdx_s6;
			kvx_s7 <= kpdx_s6 + hdy_s6;
			kvy_s7 <= kpdy_s6 - hdx_s6;
		end
		sol_s7 <= sol_s6;

		sol_d <= {sol_d[ANG_LAT-2:0], sol_s7};
	end

	tlik_angle #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_hip (
		.clk   (clk),
		.vx    (hvx_s7),
		.vy    (hvy_s7),
		.angle (hip_ang)
	);

	tlik_angle #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_knee (
		.clk   (clk),
		.vx    (kvx_s7),
		.vy    (kvy_s7),
		.angle (knee_ang)
	);

	always_ff @(posedge clk) begin
		res_q.solution_valid <= sol_d[ANG_LAT-1];
		res_q.hip_angle      <= sol_d[ANG_LAT-1] ? hip_ang : '0;
		res_q.knee_angle     <= sol_d[ANG_LAT-1] ? knee_ang : '0;
	end

	assign done = vld_q[PIPE_LAT-1];
	assign res  = res_q;

endmodule

/* hdl/tlik_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// tlik_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, resolves one root bit, registers the partial state.
// ----------------------------------------------------------------------------
module tlik_sqrt_cell (
	input  logic           clk,
	input  tlik_pkg::sqrt_t d,
	output tlik_pkg::sqrt_t q
);
	import tlik_pkg::*;

	logic [REM_W-1:0] rem2;
	logic [REM_W-1:0] trial;

	assign rem2  = {d.rem[REM_W-3:0], d.rad[RAD_W-1 -: 2]};
	assign trial = {2'b00, d.root, 2'b01};

	always_ff @(posedge clk) begin
		q.rad <= {d.rad[RAD_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			q.rem  <= rem2 - trial;
			q.root <= {d.root[H_W-2:0], 1'b1};
		end else begin
			q.rem  <= rem2;
			q.root <= {d.root[H_W-2:0], 1'b0};
		end
	end

endmodule

/* hdl/tlik_cordic_cell.sv */
// ----------------------------------------------------------------------------
// tlik_cordic_cell: one vectoring micro-rotation
// Rotates toward y = 0 and accumulates the matching arctan step.
// ----------------------------------------------------------------------------
module tlik_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  tlik_pkg::cord_t d,
	output tlik_pkg::cord_t q
);
	import tlik_pkg::*;

	logic signed [CW-1:0] sx;
	logic signed [CW-1:0] sy;

	// arithmetic shift floors, as required
	assign sx = d.x >>> IDX;
	assign sy = d.y >>> IDX;

	always_ff @(posedge clk) begin
		if (!d.y[CW-1]) begin
			q.x <= d.x + sy;
			q.y <= d.y - sx;
			q.z <= d.z + ATAN_TABLE[IDX];
		end else begin
			q.x <= d.x - sy;
			q.y <= d.y + sx;
			q.z <= d.z - ATAN_TABLE[IDX];
		end
	end

endmodule

/* hdl/tlik_angle.sv */
// ----------------------------------------------------------------------------
// tlik_angle: atan2(vx, vy) as a binary angle
// Normalize, fold into the right half plane, 32 CORDIC cells, round.
// ----------------------------------------------------------------------------
module tlik_angle #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                                     clk,
	input  logic signed [tlik_pkg::V_W-1:0]          vx,
	input  logic signed [tlik_pkg::V_W-1:0]          vy,
	output logic signed [tlik_pkg::ANG_OUT_W-1:0]    angle
);
	import tlik_pkg::*;

	localparam logic [31:0] RND = 32'(1) << (31 - ANGLE_WIDTH);

	logic signed [CW-1:0] nx [NORM_N+1];
	logic signed [CW-1:0] ny [NORM_N+1];
	logic [M_W-1:0]       nm [NORM_N+1];
	logic [V_W-1:0]       ax;
	logic [V_W-1:0]       ay;

	cord_t                cc [CORDIC_N+1];
	logic [CORDIC_N:0]    zero_q;
	logic [31:0]          zr;
	logic [ANGLE_WIDTH-1:0] code;

	// x takes vy and y takes vx: angle measured from +Y
	assign ax = vx[V_W-1] ? V_W'(-vx) : V_W'(vx);
	assign ay = vy[V_W-1] ? V_W'(-vy) : V_W'(vy);
	assign nx[0] = CW'(vy);
	assign ny[0] = CW'(vx);
	assign nm[0] = (ax > ay) ? ax : ay;

	// binary search for the doubling count: shifts of 32,16,...,1
	for (genvar s = 0; s < NORM_N; s++) begin : g_norm
		localparam int SH = 1 << (NORM_N - 1 - s);
		logic dbl;
		assign dbl = (nm[s] >> (NORM_TOP + 1 - SH)) == '0;
		always_ff @(posedge clk) begin
			nx[s+1] <= dbl ? (nx[s] <<< SH) : nx[s];
			ny[s+1] <= dbl ? (ny[s] <<< SH) : ny[s];
			nm[s+1] <= dbl ? (nm[s] << SH) : nm[s];
		end
	end

	always_ff @(posedge clk) begin
		if (nx[NORM_N][CW-1]) begin
			cc[0].x <= -nx[NORM_N];
			cc[0].y <= -ny[NORM_N];
			cc[0].z <= 32'h8000_0000;
		end else begin
			cc[0].x <= nx[NORM_N];
			cc[0].y <= ny[NORM_N];
			cc[0].z <= '0;
		end
		zero_q <= {zero_q[CORDIC_N-1:0], nm[NORM_N] == '0};
	end

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
		tlik_cordic_cell #(.IDX(i)) u_cell (
			.clk (clk),
			.d   (cc[i]),
			.q   (cc[i+1])
		);
	end

	assign zr   = cc[CORDIC_N].z + RND;
	assign code = zr[31 -: ANGLE_WIDTH];

	always_ff @(posedge clk) begin
		angle <= zero_q[CORDIC_N] ? '0 : ANG_OUT_W'(code);
	end

endmodule

/* hdl/tlik_checker.sv */
// ----------------------------------------------------------------------------
// tlik_checker: port-level checks for the leg solver
// Fixed latency pairing of requests and results, zeroed angles on no solution.
// ----------------------------------------------------------------------------
module tlik_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  logic           done,
	input  tlik_pkg::res_t res
);
	import tlik_pkg::*;

	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LAT done)
		else $error("request without result");

	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without request");

	a_no_sol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.solution_valid |-> res.hip_angle == '0 && res.knee_angle == '0)
		else $error("nonzero angle without solution");

endmodule

bind two_link_leg_inverse_kinematics tlik_checker u_tlik_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: two-link leg inverse kinematics testbench
// Drives hip/foot requests and link lengths, predicts the knee solve with an
// integer circle intersection and a bit-exact CORDIC, and checks every result.
// ----------------------------------------------------------------------------
module tb_top;
	import tlik_pkg::*;

	localparam int LIMIT    = 400000;
	localparam int DRAIN    = PIPE_LAT + 20;
	localparam int N_RANDOM = 1250;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                req;
	logic                cfg_valid;
	logic                cfg_ready;
	cfg_idx_t            cfg_index;
	logic [LINK_W-1:0]   cfg_data;
	logic                done;
	res_t                res;

	two_link_leg_inverse_kinematics u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .res(res)
	);

	typedef struct {
		logic [LINK_W-1:0] upper;
		logic [LINK_W-1:0] lower;
		req_t              rq;
		bit                typed;
		res_t              want;
	} stim_row_t;

	logic [LINK_W-1:0] upper_len;
	logic [LINK_W-1:0] lower_len;
	res_t              pending_solves[$];
	int                errors;
	longint            cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_err(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// atan2(vx, vy) from +Y, 32-step CORDIC, rounded to 16 bits
	function automatic logic [ANG_OUT_W-1:0] heading(input longint vx, input longint vy);
		longint x, y, m, ax, ay, nx, ny;
		bit [31:0] z;
		x = vy;
		y = vx;
		z = 32'h0;
		ax = vx < 0 ? -vx : vx;
		ay = vy < 0 ? -vy : vy;
		m = ax > ay ? ax : ay;
		if (m == 0)
			return '0;
		while (m < (64'sd1 <<< NORM_TOP)) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h80000000;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + ATAN_TABLE[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - ATAN_TABLE[i];
			end
			x = nx;
			y = ny;
		end
		z = z + (32'd1 << (31 - ANG_OUT_W));
		return z[31:32-ANG_OUT_W];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic res_t knee_solve(input req_t rq, input logic [LINK_W-1:0] up,
			input logic [LINK_W-1:0] lo);
		longint dx, dy, d2, r0, r1, sum, dif, k, kp, h, hvx, hvy, kvx, kvy;
		res_t o;
		o = '0;
		r0 = up;
		r1 = lo;
		dx = longint'(rq.foot_x) - longint'(rq.hip_x);
		dy = longint'(rq.foot_y) - longint'(rq.hip_y);
		d2 = dx * dx + dy * dy;
		sum = r0 + r1;
		dif = r0 > r1 ? r0 - r1 : r1 - r0;
		if (d2 == 0 || d2 > sum * sum || d2 < dif * dif)
			return o;
		k = r0 * r0 - r1 * r1 + d2;
		kp = r1 * r1 - r0 * r0 + d2;
		h = longint'(int_sqrt(longint'(unsigned'(sum * sum - d2))
			* longint'(unsigned'(d2 - dif * dif))));
		// larger-x knee; on a tie the second point
		if (h > 0 && dy > 0) begin
			hvx = k * dx + h * dy;
			hvy = k * dy - h * dx;
			kvx = kp * dx - h * dy;
			kvy = kp * dy + h * dx;
		end else begin
			hvx = k * dx - h * dy;
			hvy = k * dy + h * dx;
			kvx = kp * dx + h * dy;
			kvy = kp * dy - h * dx;
		end
		o.solution_valid = 1'b1;
		o.hip_angle = heading(hvx, hvy);
		o.knee_angle = heading(kvx, kvy);
		return o;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_solves.size() == 0) begin
				report_err("result with no request outstanding");
			end else begin
				res_t w;
				w = pending_solves.pop_front();
				if (res.solution_valid !== w.solution_valid)
					report_err($sformatf("solution_valid %b want %b",
						res.solution_valid, w.solution_valid));
				if (res.hip_angle !== w.hip_angle)
					report_err($sformatf("hip_angle %0d want %0d",
						res.hip_angle, w.hip_angle));
				if (res.knee_angle !== w.knee_angle)
					report_err($sformatf("knee_angle %0d want %0d",
						res.knee_angle, w.knee_angle));
			end
		end
	end

	task automatic wait_idle();
		while (pending_solves.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_link(input cfg_idx_t idx, input logic [LINK_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_UPPER)
			upper_len = val;
		else
			lower_len = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_links(input logic [LINK_W-1:0] up, input logic [LINK_W-1:0] lo);
		@(negedge clk);
		start <= 1'b0;
		wait_idle();
		write_link(CFG_UPPER, up);
		write_link(CFG_LOWER, lo);
	endtask

	// start stays high across back-to-back requests
	task automatic send(input req_t rq, input bit typed, input res_t want);
		@(negedge clk);
		start <= 1'b1;
		req <= rq;
		do @(posedge clk); while (busy);
		pending_solves = {pending_solves,
			(typed ? want : knee_solve(rq, upper_len, lower_len))};
	endtask

	// each cycle idles with probability pct percent
	task automatic maybe_idle(input int pct);
		while ($urandom_range(99) < pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	function automatic logic signed [COORD_W-1:0] near(input logic signed [COORD_W-1:0] c,
			input longint span);
		longint v;
		v = longint'(c) + longint'($urandom_range(0, 2 * span)) - span;
		if (v > 32767 || v < -32768)
			v = $urandom_range(0, 65535) - 32768;
		return v[COORD_W-1:0];
	endfunction

	task automatic random_phase(input int idle_pct, input int n);
		req_t rq;
		longint span;
		repeat (n) begin
			rq = req_t'({$urandom(), $urandom()});
			span = longint'(upper_len) + longint'(lower_len);
			if (span > 65535)
				span = 65535;
			if ($urandom_range(99) < 80) begin
				rq.foot_x = near(rq.hip_x, span);
				rq.foot_y = near(rq.hip_y, span);
			end
			send(rq, 1'b0, '0);
			maybe_idle(idle_pct);
		end
	endtask

	stim_row_t rows[] = '{
		'{15'd1280, 15'd1280, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '0},
		'{15'd1280, 15'd1280, '{16'sd0, 16'sd0, 16'sd32767, 16'sd32767}, 1'b1, '0},
		'{15'd1280, 15'd1280, '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b1, '0},
		'{15'd1280, 15'd1280, '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b1, '0},
		'{15'd1280, 15'd1280, '{16'sd0, 16'sd0, 16'sd0, 16'sd2560}, 1'b0, '0},
		'{15'd1280, 15'd1280, '{16'sd0, 16'sd0, 16'sd0, -16'sd2560}, 1'b0, '0},
		'{15'd1280, 15'd1280, '{16'sd0, 16'sd0, 16'sd2560, 16'sd0}, 1'b0, '0},
		'{15'd1280, 15'd1280, '{16'sd0, 16'sd0, -16'sd2560, 16'sd0}, 1'b0, '0},
		'{15'd1280, 15'd1280, '{16'sd0, 16'sd0, 16'sd2000, 16'sd0}, 1'b0, '0},
		'{15'd1280, 15'd1280, '{16'sd100, 16'sd100, 16'sd1000, -16'sd500}, 1'b0, '0},
		'{15'd1280, 15'd1280, '{16'sd0, 16'sd0, 16'sd300, 16'sd2000}, 1'b0, '0},
		'{15'd1280, 15'd1280, '{16'sd32767, 16'sd32767, 16'sd32000, 16'sd31000}, 1'b0, '0},
		'{15'd0, 15'd1280, '{16'sd0, 16'sd0, 16'sd0, 16'sd1280}, 1'b0, '0},
		'{15'd0, 15'd1280, '{16'sd0, 16'sd0, 16'sd1280, 16'sd0}, 1'b0, '0},
		'{15'd0, 15'd1280, '{16'sd0, 16'sd0, 16'sd0, 16'sd100}, 1'b1, '0},
		'{15'd0, 15'd0, '{16'sd5, 16'sd5, 16'sd5, 16'sd5}, 1'b1, '0},
		'{15'd32767, 15'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd100}, 1'b1, '0},
		'{15'd32767, 15'd32767, '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b0, '0},
		'{15'd32767, 15'd32767, '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0}, 1'b0, '0},
		'{15'd32767, 15'd32767, '{16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b0, '0},
		'{15'd100, 15'd32767, '{16'sd0, 16'sd0, 16'sd32767, 16'sd0}, 1'b0, '0}
	};

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_UPPER;
		cfg_data = '0;
		upper_len = LINK_RESET;
		lower_len = LINK_RESET;
		errors = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].upper != upper_len || rows[i].lower != lower_len)
				set_links(rows[i].upper, rows[i].lower);
			send(rows[i].rq, rows[i].typed, rows[i].want);
		end

		set_links(LINK_RESET, LINK_RESET);
		random_phase(27, N_RANDOM * 2 / 5);
		set_links(15'd32767, 15'd32767);
		random_phase(76, N_RANDOM / 10);
		set_links(15'd0, 15'd32767);
		random_phase(76, N_RANDOM / 10);
		set_links(LINK_W'($urandom_range(0, 4000)), LINK_W'($urandom_range(0, 4000)));
		random_phase(76, N_RANDOM / 10);
		set_links(LINK_W'($urandom_range(0, 32767)), LINK_W'($urandom_range(0, 32767)));
		random_phase(0, N_RANDOM / 10);
		set_links(15'd2000, 15'd700);
		random_phase(0, N_RANDOM / 5);

		@(negedge clk);
		start <= 1'b0;
		wait_idle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
